// File: rtl/lslf_pkg.sv
package lslf_pkg;

   // sample format and run capacity
   localparam int MAX_SAMPLES = 4096;
   localparam int X_BITS      = 10;
   localparam int Y_BITS      = 16;
   localparam int FRAC_BITS   = 16;

   // accumulator widths
   localparam int LOG_N = $clog2(MAX_SAMPLES);
   localparam int CNT_W = LOG_N + 1;
   localparam int SX_W  = X_BITS + LOG_N;
   localparam int SXX_W = 2 * X_BITS + LOG_N;
   localparam int SXY_W = X_BITS + Y_BITS + LOG_N;
   localparam int SY_W  = Y_BITS + LOG_N;
   localparam int SYY_W = 2 * Y_BITS + LOG_N;

   // width of the cross products and their differences
   localparam int RW_A = CNT_W + SYY_W;
   localparam int RW_B = SY_W + SXX_W;
   localparam int RW   = (RW_A > RW_B) ? RW_A : RW_B;

   // correlation search
   localparam int CORR_FRAC = 14;
   localparam int CORR_ONE  = 1 << CORR_FRAC;
   localparam int CK_W      = CORR_FRAC + 1;
   localparam int ODD_W     = CORR_FRAC + 1;
   localparam int SQ_W      = 2 * ODD_W;

   // shift-add multiplier
   localparam int MA_W = 2 * RW + SQ_W;
   localparam int MB_W = RW;

   // divider
   localparam int DVD_W = RW + FRAC_BITS;
   localparam int DC_W  = $clog2(DVD_W + 1);

   // result formats
   localparam int OUT_W  = 48;
   localparam int CORR_W = 16;

   // multiplier operand pairs
   localparam logic [3:0] MO_NSXX   = 4'd0;
   localparam logic [3:0] MO_SXSX   = 4'd1;
   localparam logic [3:0] MO_NSXY   = 4'd2;
   localparam logic [3:0] MO_SXSY   = 4'd3;
   localparam logic [3:0] MO_SYSXX  = 4'd4;
   localparam logic [3:0] MO_SXSXY  = 4'd5;
   localparam logic [3:0] MO_NSYY   = 4'd6;
   localparam logic [3:0] MO_SYSY   = 4'd7;
   localparam logic [3:0] MO_DXDY   = 4'd8;
   localparam logic [3:0] MO_NUMNUM = 4'd9;
   localparam logic [3:0] MO_ODDSQ  = 4'd10;
   localparam logic [3:0] MO_SQP    = 4'd11;

   // capture codes for the difference of the two products
   localparam logic [2:0] CAP_NONE  = 3'd0;
   localparam logic [2:0] CAP_SING  = 3'd1;
   localparam logic [2:0] CAP_DX    = 3'd2;
   localparam logic [2:0] CAP_NUM   = 3'd3;
   localparam logic [2:0] CAP_INUM  = 3'd4;
   localparam logic [2:0] CAP_UNDEF = 3'd5;
   localparam logic [2:0] CAP_DY    = 3'd6;

   // divider destinations
   localparam logic DIV_SLOPE = 1'b0;
   localparam logic DIV_ICPT  = 1'b1;

   typedef struct packed {
      logic       acc_en;
      logic       acc_clear;
      logic       res_clear;
      logic       mul_go;
      logic [3:0] mul_op;
      logic [2:0] cap;
      logic       div_go;
      logic       div_sel;
      logic       srch_upd;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic le;
      logic srch_done;
      logic out_full;
   } status_type;

endpackage

// File: rtl/lslf_ctrl.sv
module lslf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_stall,
   input  logic                 rsp_stall,
   input  logic                 csr_write_enable,
   input  logic                 csr_write_data,
   input  lslf_pkg::status_type stat,
   output lslf_pkg::cmd_type    cmd
);
   import lslf_pkg::*;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_A1   = 5'd1;
   localparam logic [4:0] ST_A2   = 5'd2;
   localparam logic [4:0] ST_A3   = 5'd3;
   localparam logic [4:0] ST_B1   = 5'd4;
   localparam logic [4:0] ST_B2   = 5'd5;
   localparam logic [4:0] ST_B3   = 5'd6;
   localparam logic [4:0] ST_B4   = 5'd7;
   localparam logic [4:0] ST_C1   = 5'd8;
   localparam logic [4:0] ST_C2   = 5'd9;
   localparam logic [4:0] ST_C3   = 5'd10;
   localparam logic [4:0] ST_C4   = 5'd11;
   localparam logic [4:0] ST_D0   = 5'd12;
   localparam logic [4:0] ST_D1   = 5'd13;
   localparam logic [4:0] ST_D2   = 5'd14;
   localparam logic [4:0] ST_E1   = 5'd15;
   localparam logic [4:0] ST_E2   = 5'd16;
   localparam logic [4:0] ST_F1   = 5'd17;
   localparam logic [4:0] ST_F2   = 5'd18;
   localparam logic [4:0] ST_F3   = 5'd19;
   localparam logic [4:0] ST_WAIT = 5'd20;
   localparam logic [4:0] ST_OUT  = 5'd21;

   logic [4:0] state_ff, state_in;
   logic [4:0] ret_ff, ret_in;
   logic       corr_en_ff;
   logic       accept;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         corr_en_ff <= 1'b1;
      end else if (csr_write_enable) begin
         corr_en_ff <= csr_write_data;
      end
   end

   // sequencer
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.acc_en = accept;
            if (accept && req_last) begin
               cmd.res_clear = 1'b1;
               state_in      = ST_A1;
            end
         end
         ST_A1: begin
            cmd.mul_go = 1'b1; cmd.mul_op = MO_NSXX; state_in = ST_WAIT; ret_in = ST_A2;
         end
         ST_A2: begin
            cmd.mul_go = 1'b1; cmd.mul_op = MO_SXSX; state_in = ST_WAIT; ret_in = ST_A3;
         end
         ST_A3: begin
            if (stat.le) begin
               cmd.cap  = CAP_SING;
               state_in = ST_OUT;
            end else begin
               cmd.cap  = CAP_DX;
               state_in = ST_B1;
            end
         end
         ST_B1: begin
            cmd.mul_go = 1'b1; cmd.mul_op = MO_NSXY; state_in = ST_WAIT; ret_in = ST_B2;
         end
         ST_B2: begin
            cmd.mul_go = 1'b1; cmd.mul_op = MO_SXSY; state_in = ST_WAIT; ret_in = ST_B3;
         end
         ST_B3: begin
            cmd.cap  = CAP_NUM;
            state_in = ST_B4;
         end
         ST_B4: begin
            cmd.div_go = 1'b1; cmd.div_sel = DIV_SLOPE; state_in = ST_WAIT; ret_in = ST_C1;
         end
         ST_C1: begin
            cmd.mul_go = 1'b1; cmd.mul_op = MO_SYSXX; state_in = ST_WAIT; ret_in = ST_C2;
         end
         ST_C2: begin
            cmd.mul_go = 1'b1; cmd.mul_op = MO_SXSXY; state_in = ST_WAIT; ret_in = ST_C3;
         end
         ST_C3: begin
            cmd.cap  = CAP_INUM;
            state_in = ST_C4;
         end
         ST_C4: begin
            cmd.div_go = 1'b1; cmd.div_sel = DIV_ICPT; state_in = ST_WAIT; ret_in = ST_D0;
         end
         ST_D0: begin
            if (!corr_en_ff) begin
               state_in = ST_OUT;
            end else begin
               cmd.mul_go = 1'b1; cmd.mul_op = MO_NSYY; state_in = ST_WAIT; ret_in = ST_D1;
            end
         end
         ST_D1: begin
            cmd.mul_go = 1'b1; cmd.mul_op = MO_SYSY; state_in = ST_WAIT; ret_in = ST_D2;
         end
         ST_D2: begin
            if (stat.le) begin
               cmd.cap  = CAP_UNDEF;
               state_in = ST_OUT;
            end else begin
               cmd.cap  = CAP_DY;
               state_in = ST_E1;
            end
         end
         ST_E1: begin
            cmd.mul_go = 1'b1; cmd.mul_op = MO_DXDY; state_in = ST_WAIT; ret_in = ST_E2;
         end
         ST_E2: begin
            cmd.mul_go = 1'b1; cmd.mul_op = MO_NUMNUM; state_in = ST_WAIT; ret_in = ST_F1;
         end
         ST_F1: begin
            if (stat.srch_done) begin
               state_in = ST_OUT;
            end else begin
               cmd.mul_go = 1'b1; cmd.mul_op = MO_ODDSQ; state_in = ST_WAIT; ret_in = ST_F2;
            end
         end
         ST_F2: begin
            cmd.mul_go = 1'b1; cmd.mul_op = MO_SQP; state_in = ST_WAIT; ret_in = ST_F3;
         end
         ST_F3: begin
            cmd.srch_upd = 1'b1;
            state_in     = ST_F1;
         end
         ST_WAIT: begin
            if (!stat.busy) begin
               state_in = ret_ff;
            end
         end
         ST_OUT: begin
            if (!stat.out_full || !rsp_stall) begin
               cmd.out_load  = 1'b1;
               cmd.acc_clear = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

// File: rtl/lslf_dpath.sv
module lslf_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  lslf_pkg::cmd_type                   cmd,
   output lslf_pkg::status_type                stat,
   input  logic [lslf_pkg::X_BITS-1:0]         req_sample_x,
   input  logic [lslf_pkg::Y_BITS-1:0]         req_sample_y,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic signed [lslf_pkg::OUT_W-1:0]   rsp_slope,
   output logic signed [lslf_pkg::OUT_W-1:0]   rsp_intercept,
   output logic signed [lslf_pkg::CORR_W-1:0]  rsp_correlation,
   output logic                                rsp_singular,
   output logic                                rsp_correlation_undefined,
   output logic [lslf_pkg::CNT_W-1:0]          rsp_samples_used,
   output logic                                rsp_overflow
);
   import lslf_pkg::*;

   // accumulators
   logic [CNT_W-1:0] cnt_ff;
   logic [SX_W-1:0]  sx_ff;
   logic [SXX_W-1:0] sxx_ff;
   logic [SXY_W-1:0] sxy_ff;
   logic [SY_W-1:0]  sy_ff;
   logic [SYY_W-1:0] syy_ff;
   logic             ovf_ff;

   logic [2*X_BITS-1:0]      xx;
   logic [X_BITS+Y_BITS-1:0] xy;
   logic [2*Y_BITS-1:0]      yy;

   assign xx = req_sample_x * req_sample_x;
   assign xy = req_sample_x * req_sample_y;
   assign yy = req_sample_y * req_sample_y;

   always_ff @(posedge clock) begin
      if (reset || cmd.acc_clear) begin
         cnt_ff <= '0;
         sx_ff  <= '0;
         sxx_ff <= '0;
         sxy_ff <= '0;
         sy_ff  <= '0;
         syy_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.acc_en) begin
         if (cnt_ff < CNT_W'(MAX_SAMPLES)) begin
            cnt_ff <= cnt_ff + 1'b1;
            sx_ff  <= sx_ff + SX_W'(req_sample_x);
            sxx_ff <= sxx_ff + SXX_W'(xx);
            sxy_ff <= sxy_ff + SXY_W'(xy);
            sy_ff  <= sy_ff + SY_W'(req_sample_y);
            syy_ff <= syy_ff + SYY_W'(yy);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   // working registers
   logic [RW-1:0]   ra_ff, rb_ff, dx_ff, num_ff, inum_ff, dy_ff;
   logic            neg_ff, ineg_ff;
   logic [2*RW-1:0] pp_ff, rr_ff;
   logic [SQ_W-1:0] sq_ff;
   logic [MA_W-1:0] ll_ff;
   logic            le, lt;
   logic [RW-1:0]   diff;

   assign le   = (ra_ff <= rb_ff);
   assign lt   = (ra_ff < rb_ff);
   assign diff = lt ? (rb_ff - ra_ff) : (ra_ff - rb_ff);

   // correlation search bounds
   logic [CK_W-1:0]  lo_ff, hi_ff;
   logic [CK_W:0]    mid_sum;
   logic [CK_W-1:0]  mid;
   logic [ODD_W-1:0] odd;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} + 1'b1;
   assign mid     = mid_sum[CK_W:1];
   assign odd     = ODD_W'({mid, 1'b0} - 1'b1);

   // shift-add multiplier, one multiplier bit per cycle
   logic [MA_W-1:0] ma_ff, mp_ff, ma_in;
   logic [MB_W-1:0] mb_ff, mb_in;
   logic            mbusy_ff;
   logic [3:0]      mop_ff;
   logic            mdone;

   assign mdone = mbusy_ff && (mb_ff == '0);

   always_comb begin
      case (cmd.mul_op)
         MO_NSXX:   begin ma_in = MA_W'(cnt_ff); mb_in = MB_W'(sxx_ff); end
         MO_SXSX:   begin ma_in = MA_W'(sx_ff);  mb_in = MB_W'(sx_ff);  end
         MO_NSXY:   begin ma_in = MA_W'(cnt_ff); mb_in = MB_W'(sxy_ff); end
         MO_SXSY:   begin ma_in = MA_W'(sx_ff);  mb_in = MB_W'(sy_ff);  end
         MO_SYSXX:  begin ma_in = MA_W'(sy_ff);  mb_in = MB_W'(sxx_ff); end
         MO_SXSXY:  begin ma_in = MA_W'(sx_ff);  mb_in = MB_W'(sxy_ff); end
         MO_NSYY:   begin ma_in = MA_W'(cnt_ff); mb_in = MB_W'(syy_ff); end
         MO_SYSY:   begin ma_in = MA_W'(sy_ff);  mb_in = MB_W'(sy_ff);  end
         MO_DXDY:   begin ma_in = MA_W'(dx_ff);  mb_in = MB_W'(dy_ff);  end
         MO_NUMNUM: begin ma_in = MA_W'(num_ff); mb_in = MB_W'(num_ff); end
         MO_ODDSQ:  begin ma_in = MA_W'(odd);    mb_in = MB_W'(odd);    end
         MO_SQP:    begin ma_in = MA_W'(pp_ff);  mb_in = MB_W'(sq_ff);  end
         default:   begin ma_in = '0;            mb_in = '0;            end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
      end else if (cmd.mul_go) begin
         mbusy_ff <= 1'b1;
      end else if (mdone) begin
         mbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_go) begin
         ma_ff  <= ma_in;
         mb_ff  <= mb_in;
         mp_ff  <= '0;
         mop_ff <= cmd.mul_op;
      end else if (mbusy_ff && !mdone) begin
         if (mb_ff[0]) begin
            mp_ff <= mp_ff + ma_ff;
         end
         ma_ff <= ma_ff << 1;
         mb_ff <= mb_ff >> 1;
      end
   end

   // product capture
   always_ff @(posedge clock) begin
      if (mdone) begin
         case (mop_ff)
            MO_NSXX, MO_NSXY, MO_SYSXX, MO_NSYY: ra_ff <= mp_ff[RW-1:0];
            MO_SXSX, MO_SXSY, MO_SXSXY, MO_SYSY: rb_ff <= mp_ff[RW-1:0];
            MO_DXDY:   pp_ff <= mp_ff[2*RW-1:0];
            MO_NUMNUM: rr_ff <= mp_ff[2*RW-1:0];
            MO_ODDSQ:  sq_ff <= mp_ff[SQ_W-1:0];
            MO_SQP:    ll_ff <= mp_ff;
            default: begin
            end
         endcase
      end
   end

   // difference capture
   always_ff @(posedge clock) begin
      case (cmd.cap)
         CAP_DX: dx_ff <= diff;
         CAP_NUM: begin
            num_ff <= diff;
            neg_ff <= lt;
         end
         CAP_INUM: begin
            inum_ff <= diff;
            ineg_ff <= lt;
         end
         CAP_DY: dy_ff <= diff;
         default: begin
         end
      endcase
   end

   // restoring divider, one quotient bit per cycle, then round and clamp
   logic [RW-1:0]    drem_ff;
   logic [DVD_W-1:0] dq_ff;
   logic [DC_W-1:0]  dcnt_ff;
   logic             dbusy_ff, dsel_ff, dneg_ff;
   logic [RW:0]      dtry;
   logic             dge;
   logic             drnd;
   logic [DVD_W:0]   dqr, dlim, dmag;
   logic [OUT_W-1:0] dres;
   logic             dfin;

   assign dtry = {drem_ff, dq_ff[DVD_W-1]};
   assign dge  = (dtry >= {1'b0, dx_ff});
   assign drnd = ({drem_ff, 1'b0} >= {1'b0, dx_ff});
   assign dqr  = {1'b0, dq_ff} + (DVD_W+1)'(drnd);
   assign dlim = dneg_ff ? ((DVD_W+1)'(1) << (OUT_W-1))
                         : (((DVD_W+1)'(1) << (OUT_W-1)) - 1'b1);
   assign dmag = (dqr > dlim) ? dlim : dqr;
   assign dres = dneg_ff ? (OUT_W'(0) - dmag[OUT_W-1:0]) : dmag[OUT_W-1:0];
   assign dfin = dbusy_ff && (dcnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (cmd.div_go) begin
         dbusy_ff <= 1'b1;
      end else if (dfin) begin
         dbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_go) begin
         drem_ff <= '0;
         dq_ff   <= (cmd.div_sel == DIV_ICPT) ? {inum_ff, FRAC_BITS'(0)}
                                              : {num_ff, FRAC_BITS'(0)};
         dneg_ff <= (cmd.div_sel == DIV_ICPT) ? ineg_ff : neg_ff;
         dsel_ff <= cmd.div_sel;
         dcnt_ff <= DC_W'(DVD_W);
      end else if (dbusy_ff && !dfin) begin
         drem_ff <= dge ? RW'(dtry - {1'b0, dx_ff}) : dtry[RW-1:0];
         dq_ff   <= {dq_ff[DVD_W-2:0], dge};
         dcnt_ff <= dcnt_ff - 1'b1;
      end
   end

   // fit results
   logic [OUT_W-1:0] slope_ff, icpt_ff;
   logic             sing_ff, undef_ff;

   always_ff @(posedge clock) begin
      if (cmd.res_clear) begin
         slope_ff <= '0;
         icpt_ff  <= '0;
         sing_ff  <= 1'b0;
         undef_ff <= 1'b0;
         lo_ff    <= '0;
         hi_ff    <= CK_W'(CORR_ONE);
      end else begin
         if (cmd.cap == CAP_SING) begin
            sing_ff <= 1'b1;
         end
         if (cmd.cap == CAP_UNDEF) begin
            undef_ff <= 1'b1;
         end
         if (dfin && (dsel_ff == DIV_SLOPE)) begin
            slope_ff <= dres;
         end
         if (dfin && (dsel_ff == DIV_ICPT)) begin
            icpt_ff <= dres;
         end
         if (cmd.srch_upd) begin
            if (ll_ff <= {rr_ff, SQ_W'(0)}) begin
               lo_ff <= mid;
            end else begin
               hi_ff <= mid - 1'b1;
            end
         end
      end
   end

   // output register
   logic             rsp_valid_ff;
   logic [CORR_W-1:0] corr_mag;

   assign corr_mag = CORR_W'(lo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_slope                 <= slope_ff;
         rsp_intercept             <= icpt_ff;
         rsp_correlation           <= neg_ff ? (CORR_W'(0) - corr_mag) : corr_mag;
         rsp_singular              <= sing_ff;
         rsp_correlation_undefined <= undef_ff;
         rsp_samples_used          <= cnt_ff;
         rsp_overflow              <= ovf_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign stat.busy      = mbusy_ff || dbusy_ff;
   assign stat.le        = le;
   assign stat.srch_done = !(lo_ff < hi_ff);
   assign stat.out_full  = rsp_valid_ff;

   // checks
   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.mul_go || cmd.div_go) |-> !(mbusy_ff || dbusy_ff))
      else $error("unit started while busy");
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten before taken");
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_singular) |-> (rsp_slope == '0 && rsp_intercept == '0))
      else $error("singular fit with nonzero line");
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count above capacity");

endmodule

// File: rtl/least_squares_line_fit.sv
// samples: one beat per cycle while no fit is in progress
// fit after the last beat: each product runs in the shift-add multiplier
// until the multiplier bits run out, each of the two divides runs through all
// dividend bits, and the correlation search up to 15 rounds of two products
// reset (synchronous, active high) clears sums, control and output valid;
// correlation enable resets to 1
module least_squares_line_fit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lslf_pkg::X_BITS-1:0]         req_sample_x,
   input  logic [lslf_pkg::Y_BITS-1:0]         req_sample_y,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lslf_pkg::OUT_W-1:0]   rsp_slope,
   output logic signed [lslf_pkg::OUT_W-1:0]   rsp_intercept,
   output logic signed [lslf_pkg::CORR_W-1:0]  rsp_correlation,
   output logic                                rsp_singular,
   output logic                                rsp_correlation_undefined,
   output logic [lslf_pkg::CNT_W-1:0]          rsp_samples_used,
   output logic                                rsp_overflow,
   input  logic                                csr_write_enable,
   input  logic                                csr_write_data
);
   import lslf_pkg::*;

   cmd_type    cmd;
   status_type stat;

   lslf_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_last         (req_last),
      .req_stall        (req_stall),
      .rsp_stall        (rsp_stall),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .stat             (stat),
      .cmd              (cmd)
   );

   lslf_dpath u_dpath (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .stat                      (stat),
      .req_sample_x              (req_sample_x),
      .req_sample_y              (req_sample_y),
      .rsp_stall                 (rsp_stall),
      .rsp_valid                 (rsp_valid),
      .rsp_slope                 (rsp_slope),
      .rsp_intercept             (rsp_intercept),
      .rsp_correlation           (rsp_correlation),
      .rsp_singular              (rsp_singular),
      .rsp_correlation_undefined (rsp_correlation_undefined),
      .rsp_samples_used          (rsp_samples_used),
      .rsp_overflow              (rsp_overflow)
   );

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import lslf_pkg::*;

   // one fit as it leaves the block
   typedef struct packed {
      logic signed [OUT_W-1:0]  slope;
      logic signed [OUT_W-1:0]  intercept;
      logic signed [CORR_W-1:0] correlation;
      logic                     singular;
      logic                     corr_undef;
      logic [CNT_W-1:0]         used;
      logic                     overflow;
   } line_fit_type;

   // running sums and the fits they predict
   class fit_scoreboard_type;
      logic [127:0] n, sx, sxx, sxy, sy, syy;
      bit           over_cap;
      bit           corr_en;
      line_fit_type fits_due[$];
      int           errors;

      function new();
         corr_en = 1'b1;
         clear_sums();
      endfunction

      function void clear_sums();
         n = 0; sx = 0; sxx = 0; sxy = 0; sy = 0; syy = 0;
         over_cap = 1'b0;
      endfunction

      // rounded (mag << FRAC_BITS) / d, clamped to the 48-bit range
      function logic [OUT_W-1:0] fixed_quotient(logic [127:0] mag, bit neg, logic [127:0] d);
         logic [127:0] num, q, r, lim;
         num = mag << FRAC_BITS;
         q = num / d;
         r = num % d;
         if (2 * r >= d) q = q + 1;
         lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
         if (q > lim) q = lim;
         return neg ? OUT_W'(-q) : q[OUT_W-1:0];
      endfunction

      // largest k with (2k-1)^2 * dx * dy <= num^2 * 2^30
      function logic [15:0] corr_mag(logic [127:0] num, logic [127:0] dx, logic [127:0] dy);
         logic [255:0] rhs, lhs, odd, lo, hi, mid;
         rhs = {128'd0, num};
         rhs = (rhs * rhs) << 30;
         lo = 0;
         hi = CORR_ONE;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            odd = 2 * mid - 1;
            lhs = odd * odd * {128'd0, dx} * {128'd0, dy};
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
         end
         return lo[15:0];
      endfunction

      function void note_sample(logic [X_BITS-1:0] x, logic [Y_BITS-1:0] y, logic last);
         logic [127:0] xw, yw, a, b, dx, dy, num, inum;
         bit           neg, ineg;
         line_fit_type f;
         xw = x;
         yw = y;
         if (n < MAX_SAMPLES) begin
            n++;
            sx += xw; sxx += xw * xw; sxy += xw * yw; sy += yw; syy += yw * yw;
         end else begin
            over_cap = 1'b1;
         end
         if (!last) return;
         f = '{default: '0};
         a = n * sxx;
         b = sx * sx;
         if (a <= b) begin
            f.singular = 1'b1;
         end else begin
            dx = a - b;
            a = n * sxy;
            b = sx * sy;
            neg = a < b;
            num = neg ? b - a : a - b;
            f.slope = fixed_quotient(num, neg, dx);
            a = sy * sxx;
            b = sx * sxy;
            ineg = a < b;
            inum = ineg ? b - a : a - b;
            f.intercept = fixed_quotient(inum, ineg, dx);
            if (corr_en) begin
               a = n * syy;
               b = sy * sy;
               if (a <= b) begin
                  f.corr_undef = 1'b1;
               end else begin
                  dy = a - b;
                  f.correlation = corr_mag(num, dx, dy);
                  if (neg) f.correlation = -f.correlation;
               end
            end
         end
         f.used = n[CNT_W-1:0];
         f.overflow = over_cap;
         fits_due.insert(fits_due.size(), f);
         clear_sums();
      endfunction

      function void check_fit(line_fit_type got);
         line_fit_type want;
         if (fits_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected fit beat: slope %0d intercept %0d",
                                       got.slope, got.intercept);
            return;
         end
         want = fits_due.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) begin
               $display("fit mismatch, expected: slope %0d icpt %0d corr %0d sing %0b und %0b n %0d ovf %0b",
                        want.slope, want.intercept, want.correlation, want.singular,
                        want.corr_undef, want.used, want.overflow);
               $display("                actual: slope %0d icpt %0d corr %0d sing %0b und %0b n %0d ovf %0b",
                        got.slope, got.intercept, got.correlation, got.singular,
                        got.corr_undef, got.used, got.overflow);
            end
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [X_BITS-1:0]        req_sample_x;
   logic [Y_BITS-1:0]        req_sample_y;
   logic                     req_last;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [OUT_W-1:0]  rsp_slope;
   logic signed [OUT_W-1:0]  rsp_intercept;
   logic signed [CORR_W-1:0] rsp_correlation;
   logic                     rsp_singular;
   logic                     rsp_correlation_undefined;
   logic [CNT_W-1:0]         rsp_samples_used;
   logic                     rsp_overflow;
   logic                     csr_write_enable;
   logic                     csr_write_data;

   fit_scoreboard_type sb;
   bit                 tx_gaps;
   bit                 hold_off;
   int                 sent;

   least_squares_line_fit uut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_sample_x              (req_sample_x),
      .req_sample_y              (req_sample_y),
      .req_last                  (req_last),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_slope                 (rsp_slope),
      .rsp_intercept             (rsp_intercept),
      .rsp_correlation           (rsp_correlation),
      .rsp_singular              (rsp_singular),
      .rsp_correlation_undefined (rsp_correlation_undefined),
      .rsp_samples_used          (rsp_samples_used),
      .rsp_overflow              (rsp_overflow),
      .csr_write_enable          (csr_write_enable),
      .csr_write_data            (csr_write_data)
   );

   // clock
   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // overall time limit
   initial begin
      #200_000_000;
      $display("least_squares_line_fit test failed");
      $finish;
   end

   // gap length: mostly short, a few long
   function int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 88) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // one sample beat, entered and left at a falling edge
   task send_sample(int x, int y, bit last);
      int gap;
      gap = tx_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_sample_x <= x[X_BITS-1:0];
      req_sample_y <= y[Y_BITS-1:0];
      req_last     <= last;
      do @(posedge clock); while (req_stall);
      sb.note_sample(x[X_BITS-1:0], y[Y_BITS-1:0], last);
      sent++;
      @(negedge clock);
   endtask

   // wait for all fits, then write the correlation enable
   task write_corr_enable(bit value);
      req_valid <= 1'b0;
      while (sb.fits_due.size() > 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.corr_en = value;
   endtask

   // one run of random content shaped by kind
   task send_run(int len, int kind);
      int x, y, base, slope, cx, cy;
      base  = $urandom_range(0, 40000);
      slope = $urandom_range(0, 120) - 60;
      cx    = $urandom_range(0, 1023);
      cy    = $urandom_range(0, 65535);
      for (int i = 0; i < len; i++) begin
         x = (kind == 2) ? cx : $urandom_range(0, 1023);
         case (kind)
            1: begin
               y = base + slope * x + $urandom_range(0, 400) - 200;
               if (y < 0) y = 0;
               if (y > 65535) y = 65535;
            end
            3: y = cy;
            4: begin
               x = $urandom_range(0, 1) ? 1023 : 0;
               y = $urandom_range(0, 1) ? 65535 : 0;
            end
            default: y = $urandom_range(0, 65535);
         endcase
         send_sample(x, y, i == len - 1);
      end
   endtask

   // result side: random stalls, one long hold-off, check each beat
   initial begin
      int stall_left;
      int mode_left;
      bit rx_gaps;
      stall_left = 0;
      mode_left = 0;
      rx_gaps = 1'b1;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            rx_gaps = $urandom_range(0, 3) != 0;
            mode_left = $urandom_range(200, 800);
         end
         mode_left--;
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (4000) @(negedge clock);
            hold_off = 1'b0;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = rx_gaps ? pick_gap() : 0;
         end
      end
   end

   always @(posedge clock) begin
      line_fit_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.slope       = rsp_slope;
         got.intercept   = rsp_intercept;
         got.correlation = rsp_correlation;
         got.singular    = rsp_singular;
         got.corr_undef  = rsp_correlation_undefined;
         got.used        = rsp_samples_used;
         got.overflow    = rsp_overflow;
         sb.check_fit(got);
      end
   end

   // stimulus
   initial begin
      int runs;
      sb = new();
      tx_gaps = 1'b1;
      hold_off = 1'b0;
      sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_x = '0;
      req_sample_y = '0;
      req_last = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: one sample, repeated x, flat y, rising and falling lines
      send_sample(5, 7, 1);
      send_sample(3, 0, 0);
      send_sample(3, 65535, 1);
      send_sample(0, 100, 0);
      send_sample(1023, 100, 1);
      send_sample(0, 0, 0);
      send_sample(1023, 65535, 0);
      send_sample(512, 32768, 1);
      send_sample(0, 65535, 0);
      send_sample(1023, 0, 1);
      send_sample(1, 65535, 0);
      send_sample(2, 0, 0);
      send_sample(0, 65534, 1);

      // correlation off, then back on
      write_corr_enable(1'b0);
      send_sample(0, 0, 0);
      send_sample(1023, 65535, 1);
      send_sample(7, 9, 0);
      send_sample(900, 9, 1);
      write_corr_enable(1'b1);

      // random runs with enable changes between phases
      sent = 0;
      runs = 0;
      while (sent < 1400) begin
         int p, len, kind;
         p = $urandom_range(0, 99);
         len = (p < 8) ? 1 : (p < 95) ? $urandom_range(2, 30) : $urandom_range(100, 250);
         p = $urandom_range(0, 99);
         kind = (p < 40) ? 1 : (p < 75) ? 0 : (p < 83) ? 2 : (p < 92) ? 3 : 4;
         if (runs % 16 == 0) tx_gaps = $urandom_range(0, 3) != 0;
         if (runs == 10) hold_off = 1'b1;
         if (runs > 0 && runs % 20 == 0) write_corr_enable($urandom_range(0, 1));
         send_run(len, kind);
         runs++;
      end
      req_valid <= 1'b0;

      // drain
      while (sb.fits_due.size() > 0) @(negedge clock);
      repeat (3000) @(negedge clock);
      if (sb.errors == 0 && sb.fits_due.size() == 0)
         $display("least_squares_line_fit test passed");
      else
         $display("least_squares_line_fit test failed");
      $finish;
   end

endmodule

// File: filelist.f
rtl/lslf_pkg.sv
rtl/lslf_ctrl.sv
rtl/lslf_dpath.sv
rtl/least_squares_line_fit.sv
verif/tb.sv
